// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/sbp_pkg.sv -----
// types, codes and tables of the stepper bin positioner
package sbp_pkg;

   localparam int PHASE_COUNT = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_SORT = 2'd1,
      KIND_HOME = 2'd2,
      KIND_HALL = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_0       = 3'd0,
      CSR_PHASE_1       = 3'd1,
      CSR_PHASE_2       = 3'd2,
      CSR_PHASE_3       = 3'd3,
      CSR_ACCEL_LENGTH  = 3'd4,
      CSR_BASE_DELAY    = 3'd5,
      CSR_QUARTER_STEPS = 3'd6
   } csr_index_type;

   // bin position and material codes share one encoding
   localparam logic [2:0] BIN_UNKNOWN  = 3'd0;
   localparam logic [2:0] BIN_ALUMINUM = 3'd1;
   localparam logic [2:0] BIN_STEEL    = 3'd2;
   localparam logic [2:0] BIN_WHITE    = 3'd3;
   localparam logic [2:0] BIN_BLACK    = 3'd4;

   localparam logic signed [6:0] RAMP_START = 7'sd10;

   // clockwise slot: black 0, aluminum 1, white 2, steel 3
   function automatic logic [1:0] slot_of(input logic [2:0] code);
      logic [1:0] slot;
      case (code)
         BIN_ALUMINUM: slot = 2'd1;
         BIN_STEEL:    slot = 2'd3;
         BIN_WHITE:    slot = 2'd2;
         default:      slot = 2'd0;
      endcase
      return slot;
   endfunction

endpackage

// ----- rtl/sbp_ifs.sv -----
// valid/ready channel interfaces for requests, responses and csr writes
interface sbp_req_if import sbp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [2:0] material;

   modport source  (output valid, kind, material, input ready);
   modport sink    (input valid, kind, material, output ready);
   modport monitor (input valid, ready, kind, material);
endinterface

interface sbp_rsp_if import sbp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] coil_pattern;
   logic       moving;
   logic       sort_done;
   logic [2:0] bin_position;

   modport source  (output valid, coil_pattern, moving, sort_done, bin_position, input ready);
   modport sink    (input valid, coil_pattern, moving, sort_done, bin_position, output ready);
   modport monitor (input valid, ready, coil_pattern, moving, sort_done, bin_position);
endinterface

interface sbp_csr_if import sbp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source  (output valid, index, data, input ready);
   modport sink    (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

// ----- rtl/stepper_bin_positioner_core.sv -----
// stepper bin positioner: event-driven trapezoidal-ramp stepper sequencer
// latency: a result beat is valid the cycle after its request beat is taken
// throughput: one request per cycle while responses are taken; all state updates in one pass of logic
//   between the request handshake and the response register
// reset: synchronous, active high; position unknown, idle, ramp at ten,
//   csr registers at their default values, no response pending
module stepper_bin_positioner_core import sbp_pkg::*; #(
   parameter int HOME_STEP_TICKS = 16
) (
   input  logic         clock,
   input  logic         reset,
   sbp_req_if.sink      req_bus,
   sbp_rsp_if.source    rsp_bus,
   sbp_csr_if.sink      csr_bus
);

   localparam logic [8:0] HOME_WAIT = 9'(HOME_STEP_TICKS);

   // csr registers
   logic [7:0]  phase_pattern_ff [PHASE_COUNT];
   logic [4:0]  accel_length_ff;
   logic [7:0]  base_delay_ff;
   logic [9:0]  quarter_steps_ff;

   // positioning state
   logic [1:0]        phase_index_ff,   phase_index_in;
   logic [2:0]        bin_now_ff,       bin_now_in;
   logic [2:0]        bin_target_ff,    bin_target_in;
   logic              move_active_ff,   move_active_in;
   logic              move_ccw_ff,      move_ccw_in;
   logic [10:0]       steps_total_ff,   steps_total_in;
   logic [10:0]       steps_taken_ff,   steps_taken_in;
   logic signed [6:0] ramp_offset_ff,   ramp_offset_in;
   logic [8:0]        wait_left_ff,     wait_left_in;
   logic              homing_active_ff, homing_active_in;
   logic              home_found_ff,    home_found_in;

   // response register
   logic       rsp_valid_ff;
   logic [7:0] coil_pattern_ff;
   logic       moving_ff;
   logic       sort_done_ff;
   logic [2:0] bin_position_ff;

   logic              req_accept;
   logic              busy;
   logic              done;
   logic              do_step;
   logic              home_step;
   logic [1:0]        slot_gap;
   logic [2:0]        material;
   kind_type          kind;
   logic signed [6:0] ramp_step;
   logic signed [9:0] delay_sum;
   logic [11:0]       decel_sum;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign kind     = kind_type'(req_bus.kind);
   assign material = req_bus.material;
   assign busy     = move_active_ff || homing_active_ff;
   assign slot_gap = slot_of(material) - slot_of(bin_now_ff);

   always_comb begin
      phase_index_in   = phase_index_ff;
      bin_now_in       = bin_now_ff;
      bin_target_in    = bin_target_ff;
      move_active_in   = move_active_ff;
      move_ccw_in      = move_ccw_ff;
      steps_total_in   = steps_total_ff;
      steps_taken_in   = steps_taken_ff;
      ramp_offset_in   = ramp_offset_ff;
      wait_left_in     = wait_left_ff;
      homing_active_in = homing_active_ff;
      home_found_in    = home_found_ff;
      done             = 1'b0;
      do_step          = 1'b0;
      home_step        = 1'b0;
      ramp_step        = ramp_offset_ff;
      delay_sum        = '0;
      decel_sum        = '0;

      if (req_accept) begin
         case (kind)
            KIND_TICK: begin
               if (busy && wait_left_ff != 9'd0) begin
                  wait_left_in = wait_left_ff - 9'd1;
                  if (wait_left_ff == 9'd1) begin
                     if (move_active_ff) begin
                        if (steps_taken_ff < steps_total_ff) begin
                           do_step = 1'b1;
                        end else begin
                           move_active_in = 1'b0;
                           bin_now_in     = bin_target_ff;
                           done           = 1'b1;
                        end
                     end else if (home_found_ff) begin
                        homing_active_in = 1'b0;
                     end else begin
                        home_step = 1'b1;
                     end
                  end
               end
            end
            KIND_SORT: begin
               if (!busy && (material inside {[BIN_ALUMINUM:BIN_BLACK]})) begin
                  if (!(bin_now_ff inside {[BIN_ALUMINUM:BIN_BLACK]})) begin
                     // unknown position: adopt the target without turning
                     bin_now_in = material;
                     done       = 1'b1;
                  end else begin
                     bin_target_in = material;
                     if (slot_gap == 2'd0) begin
                        bin_now_in = material;
                        done       = 1'b1;
                     end else begin
                        case (slot_gap)
                           2'd1: begin
                              move_ccw_in    = 1'b0;
                              steps_total_in = {1'b0, quarter_steps_ff};
                           end
                           2'd3: begin
                              move_ccw_in    = 1'b1;
                              steps_total_in = {1'b0, quarter_steps_ff};
                           end
                           default: begin
                              // half turn: clockwise except white to black
                              move_ccw_in    = (bin_now_ff == BIN_WHITE) &&
                                               (material == BIN_BLACK);
                              steps_total_in = {quarter_steps_ff, 1'b0};
                           end
                        endcase
                        steps_taken_in = '0;
                        ramp_offset_in = RAMP_START;
                        if (quarter_steps_ff == 10'd0) begin
                           bin_now_in = material;
                           done       = 1'b1;
                        end else begin
                           move_active_in = 1'b1;
                           do_step        = 1'b1;
                        end
                     end
                  end
               end
            end
            KIND_HOME: begin
               if (!busy && !home_found_ff) begin
                  homing_active_in = 1'b1;
                  home_step        = 1'b1;
               end
            end
            KIND_HALL: begin
               home_found_in = 1'b1;
               bin_now_in    = BIN_BLACK;
            end
            default: ;
         endcase
      end

      if (home_step) begin
         phase_index_in = phase_index_ff + 2'd1;
         wait_left_in   = HOME_WAIT;
      end

      // one motor step: ramp update, phase advance, next step delay
      if (do_step) begin
         ramp_step = ramp_offset_in;
         if (steps_taken_in < {6'd0, accel_length_ff}) begin
            ramp_step = ramp_step - 7'sd1;
         end
         decel_sum = {1'b0, steps_taken_in} + {7'd0, accel_length_ff};
         if (decel_sum > {1'b0, steps_total_in}) begin
            ramp_step = ramp_step + 7'sd1;
         end
         ramp_offset_in = ramp_step;
         phase_index_in = move_ccw_in ? phase_index_ff - 2'd1 : phase_index_ff + 2'd1;
         steps_taken_in = steps_taken_in + 11'd1;
         delay_sum      = $signed({2'b00, base_delay_ff}) +
                          $signed({{3{ramp_step[6]}}, ramp_step});
         wait_left_in   = (delay_sum < 10'sd1) ? 9'd1 : delay_sum[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_pattern_ff[0] <= 8'd1;
         phase_pattern_ff[1] <= 8'd2;
         phase_pattern_ff[2] <= 8'd4;
         phase_pattern_ff[3] <= 8'd8;
         accel_length_ff     <= 5'd10;
         base_delay_ff       <= 8'd20;
         quarter_steps_ff    <= 10'd50;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_index_type'(csr_bus.index))
            CSR_PHASE_0, CSR_PHASE_1, CSR_PHASE_2, CSR_PHASE_3: begin
               phase_pattern_ff[csr_bus.index[1:0]] <= csr_bus.data[7:0];
            end
            CSR_ACCEL_LENGTH:  accel_length_ff  <= csr_bus.data[4:0];
            CSR_BASE_DELAY:    base_delay_ff    <= csr_bus.data[7:0];
            CSR_QUARTER_STEPS: quarter_steps_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_index_ff   <= '0;
         bin_now_ff       <= BIN_UNKNOWN;
         bin_target_ff    <= BIN_UNKNOWN;
         move_active_ff   <= 1'b0;
         move_ccw_ff      <= 1'b0;
         steps_total_ff   <= '0;
         steps_taken_ff   <= '0;
         ramp_offset_ff   <= RAMP_START;
         wait_left_ff     <= '0;
         homing_active_ff <= 1'b0;
         home_found_ff    <= 1'b0;
      end else begin
         phase_index_ff   <= phase_index_in;
         bin_now_ff       <= bin_now_in;
         bin_target_ff    <= bin_target_in;
         move_active_ff   <= move_active_in;
         move_ccw_ff      <= move_ccw_in;
         steps_total_ff   <= steps_total_in;
         steps_taken_ff   <= steps_taken_in;
         ramp_offset_ff   <= ramp_offset_in;
         wait_left_ff     <= wait_left_in;
         homing_active_ff <= homing_active_in;
         home_found_ff    <= home_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         coil_pattern_ff <= phase_pattern_ff[phase_index_in];
         moving_ff       <= move_active_in || homing_active_in;
         sort_done_ff    <= done;
         bin_position_ff <= bin_now_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.coil_pattern = coil_pattern_ff;
   assign rsp_bus.moving       = moving_ff;
   assign rsp_bus.sort_done    = sort_done_ff;
   assign rsp_bus.bin_position = bin_position_ff;

endmodule

// ----- rtl/sbp_checker.sv -----
// port-level checks for the stepper bin positioner, bound to the positioner core
`include "assert_macros.svh"

module sbp_checker import sbp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] coil_pattern,
   input logic       moving,
   input logic       sort_done,
   input logic [2:0] bin_position
);

   logic [12:0] rsp_payload;

   assign rsp_payload = {coil_pattern, moving, sort_done, bin_position};

   // a stalled response beat keeps its payload
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // every request beat yields a response beat in the next cycle
   `ASSERT_NXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // a completed sort leaves the bin at rest on a known position
   `ASSERT_IMP(a_done_idle, clock, reset, rsp_valid && sort_done, !moving && bin_position != BIN_UNKNOWN)

   // position codes stay within unknown..black
   `ASSERT_IMP(a_pos_range, clock, reset, rsp_valid, bin_position <= BIN_BLACK)

endmodule

bind stepper_bin_positioner_core sbp_checker u_sbp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .coil_pattern (rsp_bus.coil_pattern),
   .moving       (rsp_bus.moving),
   .sort_done    (rsp_bus.sort_done),
   .bin_position (rsp_bus.bin_position)
);

// ----- tb/sbp_positioner_checker.sv -----
// bin positioner checker: predicts each response beat and compares it with the block
`timescale 1ns / 1ps

module sbp_positioner_checker import sbp_pkg::*; #(
   parameter int HOME_TICKS = 16
) (
   input  logic          clock,
   input  logic          reset,
   sbp_req_if.monitor    req_mon,
   sbp_rsp_if.monitor    rsp_mon,
   sbp_csr_if.monitor    csr_mon,
   output int            mismatches,
   output int            outstanding
);

   typedef struct {
      logic [7:0] coil;
      logic       moving;
      logic       sort_done;
      logic [2:0] bin_pos;
   } bin_status_type;

   bin_status_type expected_status[$];

   // register copies
   logic [7:0]  coil_byte [4];
   logic [4:0]  ramp_len;
   logic [7:0]  step_base;
   logic [9:0]  quarter_len;

   // motion state
   logic [1:0]  phase_idx;
   logic [2:0]  bin_now;
   logic [2:0]  bin_goal;
   logic        moving_on;
   logic        turning_ccw;
   logic [10:0] steps_total;
   logic [10:0] steps_done;
   int          ramp;
   logic [8:0]  ticks_left;
   logic        homing_on;
   logic        hall_seen;

   function automatic void clear_positioner();
      coil_byte   = '{8'd1, 8'd2, 8'd4, 8'd8};
      ramp_len    = 5'd10;
      step_base   = 8'd20;
      quarter_len = 10'd50;
      phase_idx   = 2'd0;
      bin_now     = BIN_UNKNOWN;
      bin_goal    = BIN_UNKNOWN;
      moving_on   = 1'b0;
      turning_ccw = 1'b0;
      steps_total = 11'd0;
      steps_done  = 11'd0;
      ramp        = RAMP_START;
      ticks_left  = 9'd0;
      homing_on   = 1'b0;
      hall_seen   = 1'b0;
   endfunction

   function automatic void apply_write(input csr_index_type idx,
                                       input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_PHASE_0, CSR_PHASE_1, CSR_PHASE_2, CSR_PHASE_3: coil_byte[idx[1:0]] = value[7:0];
         CSR_ACCEL_LENGTH:  ramp_len    = value[4:0];
         CSR_BASE_DELAY:    step_base   = value[7:0];
         CSR_QUARTER_STEPS: quarter_len = value[9:0];
         default: ;
      endcase
   endfunction

   // position around the turntable, counted clockwise from black
   function automatic logic [1:0] cw_slot(input logic [2:0] code);
      case (code)
         BIN_ALUMINUM: return 2'd1;
         BIN_WHITE:    return 2'd2;
         BIN_STEEL:    return 2'd3;
         default:      return 2'd0;
      endcase
   endfunction

   function automatic void step_motor();
      int k;
      int d;
      k = int'(steps_done);
      if (k < int'(ramp_len)) ramp = ramp - 1;
      if (k + int'(ramp_len) > int'(steps_total)) ramp = ramp + 1;
      phase_idx  = turning_ccw ? phase_idx - 2'd1 : phase_idx + 2'd1;
      steps_done = steps_done + 11'd1;
      d = int'(step_base) + ramp;
      if (d < 1) d = 1;
      ticks_left = d[8:0];
   endfunction

   // returns 1 when the request completes without a move
   function automatic logic begin_sort(input logic [2:0] mat);
      logic [1:0] slot_gap;
      if (mat < BIN_ALUMINUM || mat > BIN_BLACK) return 1'b0;
      if (bin_now == BIN_UNKNOWN || bin_now > BIN_BLACK) begin
         bin_now = mat;
         return 1'b1;
      end
      slot_gap = cw_slot(mat) - cw_slot(bin_now);
      bin_goal = mat;
      if (slot_gap == 2'd0) begin
         bin_now = mat;
         return 1'b1;
      end
      if (slot_gap == 2'd1) begin
         turning_ccw = 1'b0;
         steps_total = {1'b0, quarter_len};
      end else if (slot_gap == 2'd3) begin
         turning_ccw = 1'b1;
         steps_total = {1'b0, quarter_len};
      end else begin
         // half turn goes clockwise, except white to black
         turning_ccw = (bin_now == BIN_WHITE && mat == BIN_BLACK);
         steps_total = {quarter_len, 1'b0};
      end
      steps_done = 11'd0;
      ramp       = RAMP_START;
      if (steps_total == 11'd0) begin
         bin_now = bin_goal;
         return 1'b1;
      end
      moving_on = 1'b1;
      step_motor();
      return 1'b0;
   endfunction

   function automatic bin_status_type next_status(input kind_type kind, input logic [2:0] mat);
      bin_status_type s;
      logic           busy;
      logic           done;
      busy = moving_on || homing_on;
      done = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (busy && ticks_left != 9'd0) begin
               ticks_left = ticks_left - 9'd1;
               if (ticks_left == 9'd0) begin
                  if (moving_on) begin
                     if (steps_done < steps_total) begin
                        step_motor();
                     end else begin
                        moving_on = 1'b0;
                        bin_now   = bin_goal;
                        done      = 1'b1;
                     end
                  end else if (hall_seen) begin
                     homing_on = 1'b0;
                  end else begin
                     phase_idx  = phase_idx + 2'd1;
                     ticks_left = 9'(HOME_TICKS);
                  end
               end
            end
         end
         KIND_SORT: begin
            if (!busy) done = begin_sort(mat);
         end
         KIND_HOME: begin
            if (!busy && !hall_seen) begin
               homing_on  = 1'b1;
               phase_idx  = phase_idx + 2'd1;
               ticks_left = 9'(HOME_TICKS);
            end
         end
         default: begin
            hall_seen = 1'b1;
            bin_now   = BIN_BLACK;
         end
      endcase
      s.coil      = coil_byte[phase_idx];
      s.moving    = moving_on || homing_on;
      s.sort_done = done;
      s.bin_pos   = bin_now;
      return s;
   endfunction

   task automatic report(input string field, input logic [7:0] want, input logic [7:0] seen);
      $display("%0t: %s expected %0h, got %0h", $time, field, want, seen);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      bin_status_type want;
      if (reset) begin
         clear_positioner();
         expected_status.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            apply_write(csr_index_type'(csr_mon.index), csr_mon.data);
         // response first: a beat taken on this edge cannot be answered on it
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got coil %0h moving %0b done %0b bin %0d",
                        $time, rsp_mon.coil_pattern, rsp_mon.moving, rsp_mon.sort_done,
                        rsp_mon.bin_position);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_mon.coil_pattern !== want.coil)
                  report("coil_pattern", want.coil, rsp_mon.coil_pattern);
               if (rsp_mon.moving !== want.moving)
                  report("moving", 8'(want.moving), 8'(rsp_mon.moving));
               if (rsp_mon.sort_done !== want.sort_done)
                  report("sort_done", 8'(want.sort_done), 8'(rsp_mon.sort_done));
               if (rsp_mon.bin_position !== want.bin_pos)
                  report("bin_position", 8'(want.bin_pos), 8'(rsp_mon.bin_position));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_status.push_back(next_status(kind_type'(req_mon.kind), req_mon.material));
      end
      outstanding = expected_status.size();
   end

endmodule

// ----- tb/tb_stepper_bin_positioner_core.sv -----
// bin positioner testbench top: clock, reset, event stimulus and the verdict
`timescale 1ns / 1ps

module tb_stepper_bin_positioner_core;
   import sbp_pkg::*;

   localparam int HOME_TICKS  = 16;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   sent;
   int   got;
   int   cycles;
   int   mismatches;
   int   outstanding;
   logic last_moving = 1'b0;
   bit   long_hold_done;
   int   hold_left;

   sbp_req_if req_bus ();
   sbp_rsp_if rsp_bus ();
   sbp_csr_if csr_bus ();

   stepper_bin_positioner_core #(.HOME_STEP_TICKS(HOME_TICKS)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sbp_positioner_checker #(.HOME_TICKS(HOME_TICKS)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("stepper_bin_positioner_core: mismatch");
         $finish;
      end else if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got++;
         last_moving = rsp_bus.moving;
      end
   end

   // result side: random stalls, one long hold-off, one calm stretch
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (!long_hold_done && got >= 450) begin
            long_hold_done = 1'b1;
            hold_left      = 150;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= (got >= 200 && got < 350) || $urandom_range(99) >= 11;
         end
      end
   end

   function automatic logic [2:0] any_material();
      return 3'($urandom_range(7));
   endfunction

   function automatic logic [2:0] pick_material();
      if ($urandom_range(99) < 88) return 3'($urandom_range(BIN_ALUMINUM, BIN_BLACK));
      return 3'($urandom_range(5, 8));  // 0, 5, 6 or 7
   endfunction

   task automatic send_beat(input kind_type kind, input logic [2:0] mat);
      @(negedge clock);
      while (!(sent >= 200 && sent < 350) && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.material <= mat;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   task automatic hold_input();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (got == sent);
   endtask

   // ticks until the last response shows the turntable at rest
   task automatic run_to_rest();
      do begin
         while (last_moving) send_beat(KIND_TICK, any_material());
         hold_input();
      end while (last_moving);
   endtask

   task automatic sort_and_rest(input logic [2:0] mat);
      send_beat(KIND_SORT, mat);
      run_to_rest();
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic program_positioner(input logic [7:0] p0, input logic [7:0] p1,
                                     input logic [7:0] p2, input logic [7:0] p3,
                                     input logic [4:0] accel, input logic [7:0] base,
                                     input logic [9:0] quarter);
      write_reg(CSR_PHASE_0, 10'(p0));
      write_reg(CSR_PHASE_1, 10'(p1));
      write_reg(CSR_PHASE_2, 10'(p2));
      write_reg(CSR_PHASE_3, 10'(p3));
      write_reg(CSR_ACCEL_LENGTH, 10'(accel));
      write_reg(CSR_BASE_DELAY, 10'(base));
      write_reg(CSR_QUARTER_STEPS, quarter);
   endtask

   // mostly a sort run to completion; sometimes an event lands mid-move
   task automatic random_sequence();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 70) begin
         send_beat(KIND_SORT, pick_material());
         if ($urandom_range(4) == 0) begin
            n = $urandom_range(30);
            repeat (n) send_beat(KIND_TICK, any_material());
            send_beat(kind_type'($urandom_range(3)), any_material());
         end
         run_to_rest();
      end else if (r < 76) begin
         send_beat(KIND_HOME, any_material());
      end else if (r < 82) begin
         send_beat(KIND_HALL, any_material());
      end else begin
         n = $urandom_range(1, 5);
         repeat (n) send_beat(kind_type'($urandom_range(3)), any_material());
         run_to_rest();
      end
   endtask

   task automatic run_phase(input logic [7:0] p0, input logic [7:0] p1,
                            input logic [7:0] p2, input logic [7:0] p3,
                            input logic [4:0] accel, input logic [7:0] base,
                            input logic [9:0] quarter, input int budget);
      int start;
      run_to_rest();
      program_positioner(p0, p1, p2, p3, accel, base, quarter);
      start = sent;
      while (sent - start < budget) random_sequence();
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_TICK;
      req_bus.material = BIN_UNKNOWN;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_PHASE_0;
      csr_bus.data     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: unknown position, then homing
      send_beat(KIND_SORT, BIN_UNKNOWN);
      send_beat(KIND_TICK, BIN_UNKNOWN);
      send_beat(KIND_SORT, 3'd7);
      send_beat(KIND_SORT, BIN_STEEL);
      send_beat(KIND_HOME, BIN_UNKNOWN);
      repeat (20) send_beat(KIND_TICK, any_material());
      send_beat(KIND_SORT, BIN_WHITE);
      send_beat(KIND_HOME, BIN_UNKNOWN);
      send_beat(KIND_HALL, BIN_UNKNOWN);
      run_to_rest();
      send_beat(KIND_HOME, BIN_UNKNOWN);
      run_to_rest();

      // short moves through every neighbor and half turn
      program_positioner(8'hA5, 8'h3C, 8'h0F, 8'hF0, 5'd2, 8'd1, 10'd1);
      sort_and_rest(BIN_BLACK);
      sort_and_rest(BIN_ALUMINUM);
      sort_and_rest(BIN_WHITE);
      sort_and_rest(BIN_STEEL);
      sort_and_rest(BIN_BLACK);
      sort_and_rest(BIN_WHITE);
      sort_and_rest(BIN_BLACK);
      sort_and_rest(BIN_ALUMINUM);
      sort_and_rest(BIN_STEEL);
      sort_and_rest(BIN_ALUMINUM);
      sort_and_rest(BIN_WHITE);
      sort_and_rest(BIN_ALUMINUM);
      // requests, homing and hall while a move runs
      send_beat(KIND_SORT, BIN_STEEL);
      send_beat(KIND_SORT, BIN_BLACK);
      send_beat(KIND_HOME, BIN_UNKNOWN);
      send_beat(KIND_TICK, BIN_UNKNOWN);
      send_beat(KIND_HALL, BIN_UNKNOWN);
      run_to_rest();
      sort_and_rest(3'd5);
      sort_and_rest(3'd6);

      // deep ramp on a half turn: the step delay bottoms out at one tick
      program_positioner(8'h11, 8'h22, 8'h44, 8'h88, 5'd11, 8'd1, 10'd11);
      sort_and_rest(BIN_ALUMINUM);

      // longest step delay on a single step
      program_positioner(8'h81, 8'h42, 8'h24, 8'h18, 5'd0, 8'd255, 10'd1);
      sort_and_rest(BIN_WHITE);

      run_phase(8'h00, 8'hFF, 8'hAA, 8'h55, 5'd0, 8'd1, 10'd1, 30);
      run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                5'd5, 8'd3, 10'd0, 20);
      repeat (2)
         run_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   5'($urandom_range(31)), 8'($urandom_range(1, 3)),
                   10'($urandom_range(1, 2)), 20);

      hold_input();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("stepper_bin_positioner_core: match");
      end else begin
         $display("stepper_bin_positioner_core: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sbp_pkg.sv
rtl/sbp_ifs.sv
rtl/stepper_bin_positioner_core.sv
rtl/sbp_checker.sv
tb/sbp_positioner_checker.sv
tb/tb_stepper_bin_positioner_core.sv
